// ===== sv/fbcd_pkg.sv =====
package fbcd_pkg;

    localparam int SLOT_W   = 12;
    localparam int SUM_W    = 8;
    localparam int CSUM_W   = 2 * SUM_W;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [SUM_W-1:0] SUM_INIT = 8'hFF;
    localparam logic [SUM_W:0]   SUM_MOD  = 9'd255;

    localparam logic FUNC_CHECKSUM = 1'b0;
    localparam logic FUNC_CLEAR    = 1'b1;
    localparam logic TABLE_TILE    = 1'b0;
    localparam logic TABLE_WATER   = 1'b1;

    typedef struct packed {
        logic              func;
        logic              table_sel;
        logic [SLOT_W-1:0] block_slot;
        logic              block_present;
        logic [7:0]        data_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic              changed;
        logic [CSUM_W-1:0] checksum;
        logic [SLOT_W-1:0] slot_echo;
        logic              table_echo;
    } t_out;

    // One queue entry: a finished block or a clear request
    typedef struct packed {
        logic              is_clear;
        logic              table_sel;
        logic [SLOT_W-1:0] block_slot;
        logic [CSUM_W-1:0] checksum;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

// ===== sv/fbcd_front.sv =====
module fbcd_front
    import fbcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in       i_in_data,
    input  logic      i_init_busy,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cmd      o_push_data
);

    logic [SUM_W-1:0] r_low;
    logic [SUM_W-1:0] r_high;
    logic [SUM_W:0]   s1;
    logic [SUM_W:0]   s2;
    logic             accept;
    logic             completes;

    assign o_in_ready = !i_q_status.full && !i_init_busy;
    assign accept     = i_in_valid && o_in_ready;
    // clear, absent block and last byte all end the running block
    assign completes  = (i_in_data.func == FUNC_CLEAR) || !i_in_data.block_present ||
                        i_in_data.last_byte;

    always_comb begin
        s1 = {1'b0, r_low} + {1'b0, i_in_data.data_byte};
        if (s1 > SUM_MOD) begin
            s1 = s1 - SUM_MOD;
        end
        s2 = {1'b0, r_high} + s1;
        if (s2 > SUM_MOD) begin
            s2 = s2 - SUM_MOD;
        end
    end

    assign o_push = accept && completes;

    always_comb begin
        o_push_data.is_clear   = (i_in_data.func == FUNC_CLEAR);
        o_push_data.table_sel  = i_in_data.table_sel;
        o_push_data.block_slot = i_in_data.block_slot;
        o_push_data.checksum   = i_in_data.block_present ?
                                 {s2[SUM_W-1:0], s1[SUM_W-1:0]} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= SUM_INIT;
            r_high <= SUM_INIT;
        end else if (accept) begin
            if (completes) begin
                r_low  <= SUM_INIT;
                r_high <= SUM_INIT;
            end else begin
                r_low  <= s1[SUM_W-1:0];
                r_high <= s2[SUM_W-1:0];
            end
        end
    end

endmodule

// ===== sv/fbcd_fifo.sv =====
module fbcd_fifo
    import fbcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_push_data,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.not_empty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/fbcd_back.sv =====
module fbcd_back
    import fbcd_pkg::*;
#(
    parameter int BLOCK_SLOTS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_data,
    output logic o_q_pop,
    output logic o_init_busy,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(BLOCK_SLOTS);
    localparam int EW = CSUM_W + 1;

    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    // entry = {valid, checksum}
    logic [EW-1:0]     r_tile_mem  [BLOCK_SLOTS];
    logic [EW-1:0]     r_water_mem [BLOCK_SLOTS];
    logic [EW-1:0]     r_rd_tile;
    logic [EW-1:0]     r_rd_water;

    logic [1:0]        r_state;
    logic [AW-1:0]     r_sweep_addr;
    logic              sweeping;
    logic              sweep_end;

    logic [SLOT_W-1:0] q_rem;
    logic [AW-1:0]     q_idx;

    logic              r_c_valid;
    logic              r_c_table;
    logic [SLOT_W-1:0] r_c_slot;
    logic [AW-1:0]     r_c_idx;
    logic [CSUM_W-1:0] r_c_sum;
    logic              r_byp;
    logic [CSUM_W-1:0] r_byp_sum;

    logic              r_o_valid;
    t_out              r_o_data;

    logic              c_adv;
    logic              c_free;
    logic              pop_item;
    logic              pop_clr;
    logic [EW-1:0]     old_entry;
    logic [CSUM_W-1:0] old_sum;

    // slot modulo table depth, quotient fits in eight bits
    always_comb begin
        q_rem = i_q_data.block_slot;
        for (int k = 7; k >= 0; k--) begin
            if (32'(q_rem) >= (BLOCK_SLOTS << k)) begin
                q_rem = SLOT_W'(32'(q_rem) - (BLOCK_SLOTS << k));
            end
        end
        q_idx = AW'(q_rem);
    end

    assign sweeping  = (r_state == S_INIT) || (r_state == S_CLEAR);
    assign sweep_end = (r_sweep_addr == AW'(BLOCK_SLOTS - 1));

    assign c_adv  = r_c_valid && (!r_o_valid || i_out_ready);
    assign c_free = !r_c_valid || c_adv;

    // a clear waits for the compare stage to drain so the sweep owns the write port
    assign pop_item = i_q_valid && (r_state == S_RUN) && c_free && !i_q_data.is_clear;
    assign pop_clr  = i_q_valid && (r_state == S_RUN) && !r_c_valid && i_q_data.is_clear;
    assign o_q_pop  = pop_item || pop_clr;
    assign o_init_busy = (r_state == S_INIT);

    always_ff @(posedge i_clk) begin
        if (sweeping) begin
            r_tile_mem[r_sweep_addr] <= '0;
        end else if (c_adv && (r_c_table == TABLE_TILE)) begin
            r_tile_mem[r_c_idx] <= {1'b1, r_c_sum};
        end
        if (pop_item) begin
            r_rd_tile <= r_tile_mem[q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sweeping) begin
            r_water_mem[r_sweep_addr] <= '0;
        end else if (c_adv && (r_c_table == TABLE_WATER)) begin
            r_water_mem[r_c_idx] <= {1'b1, r_c_sum};
        end
        if (pop_item) begin
            r_rd_water <= r_water_mem[q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sweep_addr <= '0;
        end else begin
            case (r_state)
                S_INIT, S_CLEAR: begin
                    r_sweep_addr <= r_sweep_addr + 1'b1;
                    if (sweep_end) begin
                        r_state      <= S_RUN;
                        r_sweep_addr <= '0;
                    end
                end
                S_RUN: begin
                    if (pop_clr) begin
                        r_state      <= S_CLEAR;
                        r_sweep_addr <= '0;
                    end
                end
                default: begin
                    r_state      <= S_INIT;
                    r_sweep_addr <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= pop_item;
        end
    end

    // read returns the old word when the compare stage writes the same entry on that edge
    always_ff @(posedge i_clk) begin
        if (pop_item) begin
            r_c_table <= i_q_data.table_sel;
            r_c_slot  <= i_q_data.block_slot;
            r_c_idx   <= q_idx;
            r_c_sum   <= i_q_data.checksum;
            r_byp     <= c_adv && (r_c_table == i_q_data.table_sel) && (r_c_idx == q_idx);
            r_byp_sum <= r_c_sum;
        end
    end

    always_comb begin
        if (r_byp) begin
            old_entry = {1'b1, r_byp_sum};
        end else if (r_c_table == TABLE_WATER) begin
            old_entry = r_rd_water;
        end else begin
            old_entry = r_rd_tile;
        end
        old_sum = old_entry[CSUM_W] ? old_entry[CSUM_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_o_data.changed    <= (old_sum != r_c_sum);
            r_o_data.checksum   <= r_c_sum;
            r_o_data.slot_echo  <= r_c_slot;
            r_o_data.table_echo <= r_c_table;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

// ===== sv/fletcher16_block_change_detector.sv =====
// Beat    | Dir | Handshake               | Payload
// input   | in  | i_in_valid/o_in_ready   | i_in_data  (t_in)
// result  | out | o_out_valid/i_out_ready | o_out_data (t_out)
//
// One beat per cycle unless the queue is full or the reset pass runs; results pass the
// queue, compare stage and output register. The hash tables are single-port-write memories
// with a registered read; the compare stage forwards its own write to a back-to-back read
// of the same entry. After reset a clearing pass over all BLOCK_SLOTS entries runs with
// o_in_ready low. A clear beat sweeps both tables; input beats keep entering the four-entry
// queue until it fills. A stalled output holds one result plus one in the pipe.
module fletcher16_block_change_detector
    import fbcd_pkg::*;
#(
    parameter int BLOCK_SLOTS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic      init_busy;
    logic      q_push;
    t_cmd      q_push_data;
    logic      q_pop;
    t_cmd      q_head;
    t_q_status q_status;

    fbcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_init_busy (init_busy),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    fbcd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    fbcd_back #(
        .BLOCK_SLOTS (BLOCK_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_status.not_empty),
        .i_q_data    (q_head),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_status.not_empty)
        else $error("queue read while empty");

    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !o_in_ready)
        else $error("input taken during reset clearing pass");

    // running sums never reach zero, so only an absent block gives a zero byte
    a_sum_bytes_zero_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.checksum[15:8] == 8'h00) ==
                         (o_out_data.checksum[7:0] == 8'h00)))
        else $error("checksum has exactly one zero byte");

endmodule

// ===== verif/tb_fletcher16_block_change_detector.sv =====
module tb_fletcher16_block_change_detector;
    import fbcd_pkg::*;

    localparam int BLOCK_SLOTS  = 4096;
    localparam int RANDOM_BEATS = 1900;
    localparam int MAX_BLOCK    = 64;
    localparam int POOL_N       = 8;
    localparam int MAX_CLEARS   = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 40;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    fletcher16_block_change_detector #(
        .BLOCK_SLOTS(BLOCK_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // stimulus and expectations
    t_in  byte_beats_todo[$];
    t_out verdicts_due[$];

    // predictor state
    logic [SUM_W-1:0]  run_low;
    logic [SUM_W-1:0]  run_high;
    logic [CSUM_W-1:0] stored_hash[2][BLOCK_SLOTS];
    bit                hash_known[2][BLOCK_SLOTS];

    // block content scratch and replay pool
    logic [7:0]        block_buf[MAX_BLOCK];
    logic [7:0]        pool_bytes[POOL_N][MAX_BLOCK];
    int                pool_len[POOL_N];
    logic              pool_tsel[POOL_N];
    logic [SLOT_W-1:0] pool_slot[POOL_N];

    int   cycle_count;
    int   faults;
    int   beats_taken;
    int   verdicts_checked;
    int   changed_seen;
    int   absent_seen;
    int   clears_taken;
    int   clears_queued;
    bit   beat_taken;
    int   burst_left;
    int   gap_left;
    int   stall_mode;
    int   stall_span;
    int   stall_phase;
    int   stall_run;
    t_out want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in mk_beat(logic f, logic tsel, logic [SLOT_W-1:0] slot, logic present,
                                    logic [7:0] data, logic last);
        t_in b;
        b.func          = f;
        b.table_sel     = tsel;
        b.block_slot    = slot;
        b.block_present = present;
        b.data_byte     = data;
        b.last_byte     = last;
        return b;
    endfunction

    task automatic add_beat(input t_in b);
        byte_beats_todo.insert(byte_beats_todo.size(), b);
    endtask

    task automatic push_block(input logic tsel, input logic [SLOT_W-1:0] slot, input int len);
        for (int i = 0; i < len; i++)
            add_beat(mk_beat(FUNC_CHECKSUM, tsel, slot, 1'b1, block_buf[i], i == len - 1));
    endtask

    task automatic push_absent(input logic tsel, input logic [SLOT_W-1:0] slot);
        add_beat(mk_beat(FUNC_CHECKSUM, tsel, slot, 1'b0,
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    endtask

    task automatic push_clear();
        add_beat(mk_beat(FUNC_CLEAR, 1'($urandom_range(0, 1)),
                         12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        clears_queued++;
    endtask

    // random content, leaning on 0x00 and 0xff now and then
    task automatic fill_block(input int len);
        int pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                block_buf[i] = 8'h00;
            else if (pick == 1)
                block_buf[i] = 8'hFF;
            else
                block_buf[i] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic track_detector_beat(input t_in b);
        int                s1;
        int                s2;
        int                idx;
        logic [CSUM_W-1:0] sum;
        logic [CSUM_W-1:0] prior;
        t_out              v;
        if (b.func == FUNC_CLEAR) begin
            for (int t = 0; t < 2; t++)
                for (int k = 0; k < BLOCK_SLOTS; k++)
                    hash_known[t][k] = 1'b0;
            run_low  = SUM_INIT;
            run_high = SUM_INIT;
            clears_taken++;
            return;
        end
        if (b.block_present) begin
            s1 = int'(run_low) + int'(b.data_byte);
            if (s1 > int'(SUM_MOD))
                s1 -= int'(SUM_MOD);
            s2 = int'(run_high) + s1;
            if (s2 > int'(SUM_MOD))
                s2 -= int'(SUM_MOD);
            run_low  = s1[SUM_W-1:0];
            run_high = s2[SUM_W-1:0];
            if (!b.last_byte)
                return;
            sum = {run_high, run_low};
        end else begin
            sum = '0;
            absent_seen++;
        end
        idx   = int'(b.block_slot) % BLOCK_SLOTS;
        prior = hash_known[b.table_sel][idx] ? stored_hash[b.table_sel][idx] : '0;
        stored_hash[b.table_sel][idx] = sum;
        hash_known[b.table_sel][idx]  = 1'b1;
        v.changed    = (prior != sum);
        v.checksum   = sum;
        v.slot_echo  = b.block_slot;
        v.table_echo = b.table_sel;
        if (v.changed)
            changed_seen++;
        verdicts_due.insert(verdicts_due.size(), v);
        run_low  = SUM_INIT;
        run_high = SUM_INIT;
    endtask

    // monitor: results first, then the input beat taken at this edge
    always @(posedge i_clk) begin
        cycle_count++;
        beat_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                faults++;
                $display("%0t: unexpected result: changed=%0b checksum=%h slot=%0d table=%0b",
                         $time, o_out_data.changed, o_out_data.checksum,
                         o_out_data.slot_echo, o_out_data.table_echo);
            end else begin
                want = verdicts_due.pop_front();
                verdicts_checked++;
                if (o_out_data.changed !== want.changed || o_out_data.checksum !== want.checksum
                    || o_out_data.slot_echo !== want.slot_echo
                    || o_out_data.table_echo !== want.table_echo) begin
                    faults++;
                    $display({"%0t: mismatch: expected changed=%0b checksum=%h slot=%0d ",
                              "table=%0b, got changed=%0b checksum=%h slot=%0d table=%0b"},
                             $time, want.changed, want.checksum, want.slot_echo,
                             want.table_echo, o_out_data.changed, o_out_data.checksum,
                             o_out_data.slot_echo, o_out_data.table_echo);
                end
            end
        end
        if (beat_taken) begin
            beats_taken++;
            track_detector_beat(i_in_data);
        end
    end

    // sender: bursts of beats with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (byte_beats_todo.size() > 0) begin
                i_in_data  <= byte_beats_todo.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches mode every so often
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(32, 256);
        end else begin
            stall_span--;
        end
        stall_phase++;
        case (stall_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_out_ready <= (stall_phase % 3 != 0);
            end
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_ready <= 1'b0;
                end else begin
                    stall_run = $urandom_range(1, 12);
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles, %0d beats taken, %0d results pending",
                 cycle_count, beats_taken, verdicts_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int directed_beats;
        int pick;
        int e;
        int len;
        run_low  = SUM_INIT;
        run_high = SUM_INIT;

        // absent block on a fresh slot: reads 0, so unchanged
        push_absent(TABLE_TILE, 12'd0);
        // extremes of the byte on the top slot, then the same block again
        block_buf[0] = 8'h00;
        block_buf[1] = 8'hFF;
        push_block(TABLE_TILE, 12'd4095, 2);
        push_block(TABLE_TILE, 12'd4095, 2);
        block_buf[0] = 8'hFF;
        push_block(TABLE_WATER, 12'd4095, 1);
        // absent replaces a real checksum, then repeats
        push_absent(TABLE_WATER, 12'd4095);
        push_absent(TABLE_WATER, 12'd4095);
        // slot and table move mid-block; the closing beat decides
        add_beat(mk_beat(FUNC_CHECKSUM, TABLE_TILE, 12'd5, 1'b1, 8'hA5, 1'b0));
        add_beat(mk_beat(FUNC_CHECKSUM, TABLE_WATER, 12'd4094, 1'b1, 8'h5A, 1'b1));
        // partial block dropped by a clear; stored entries are invalidated
        add_beat(mk_beat(FUNC_CHECKSUM, TABLE_TILE, 12'd7, 1'b1, 8'h3C, 1'b0));
        add_beat(mk_beat(FUNC_CHECKSUM, TABLE_TILE, 12'd7, 1'b1, 8'hC3, 1'b0));
        push_clear();
        block_buf[0] = 8'h00;
        block_buf[1] = 8'hFF;
        push_block(TABLE_TILE, 12'd4095, 2);
        push_absent(TABLE_TILE, 12'd0);
        // partial block dropped by an absent block
        add_beat(mk_beat(FUNC_CHECKSUM, TABLE_WATER, 12'd9, 1'b1, 8'h81, 1'b0));
        push_absent(TABLE_WATER, 12'd9);
        block_buf[0] = 8'h01;
        push_block(TABLE_WATER, 12'd9, 1);
        directed_beats = byte_beats_todo.size();

        for (int p = 0; p < POOL_N; p++) begin
            pool_len[p]  = $urandom_range(1, 16);
            pool_tsel[p] = 1'($urandom_range(0, 1));
            pool_slot[p] = 12'($urandom_range(0, 4095));
            fill_block(pool_len[p]);
            for (int i = 0; i < pool_len[p]; i++)
                pool_bytes[p][i] = block_buf[i];
        end

        while (byte_beats_todo.size() < directed_beats + RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            e    = $urandom_range(0, POOL_N - 1);
            if (pick < 78) begin
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, MAX_BLOCK)
                                                  : $urandom_range(1, 16);
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // exact replay: expected unchanged unless something intervened
                    for (int i = 0; i < pool_len[e]; i++)
                        block_buf[i] = pool_bytes[e][i];
                    push_block(pool_tsel[e], pool_slot[e], pool_len[e]);
                end else begin
                    if (pick >= 60) begin
                        pool_tsel[e] = 1'($urandom_range(0, 1));
                        pool_slot[e] = 12'($urandom_range(0, 4095));
                    end
                    fill_block(len);
                    pool_len[e] = len;
                    for (int i = 0; i < len; i++)
                        pool_bytes[e][i] = block_buf[i];
                    push_block(pool_tsel[e], pool_slot[e], len);
                end
            end else if (pick < 90) begin
                if ($urandom_range(0, 1))
                    push_absent(pool_tsel[e], pool_slot[e]);
                else
                    push_absent(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
            end else if (pick < 98 || clears_queued >= MAX_CLEARS) begin
                // stray bytes with wandering slot/table; a present block absorbs them
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add_beat(mk_beat(FUNC_CHECKSUM, 1'($urandom_range(0, 1)),
                                     12'($urandom_range(0, 4095)), 1'b1,
                                     8'($urandom_range(0, 255)), 1'b0));
            end else begin
                push_clear();
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_beats_todo.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d beats (%0d directed) in %0d cycles, %0d table clears.",
                 beats_taken, directed_beats, cycle_count, clears_taken);
        $display("Checked %0d block results: %0d changed, %0d absent blocks; %0d faults.",
                 verdicts_checked, changed_seen, absent_seen, faults);
        if (faults == 0 && verdicts_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
